// File: rtl/assert_macros.svh
// Assertion macros used by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HMM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hmm_pkg.sv
// Package: constants and codes of the histogram matching mapper.
package hmm_pkg;
   localparam int LEVELS     = 256;
   localparam int PIX_W      = 8;
   localparam int CNT_W      = 19;
   localparam int PROD_W     = 2 * CNT_W;
   localparam int HIST_DEPTH = 2 * LEVELS;
   localparam int HIST_AW    = 9;
   localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(262144);

   typedef logic [1:0] op_type;
   localparam op_type OP_COUNT_SRC = 2'd0;
   localparam op_type OP_COUNT_REF = 2'd1;
   localparam op_type OP_BUILD     = 2'd2;
   localparam op_type OP_MAP       = 2'd3;
endpackage

// File: rtl/hmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/histogram_matching_mapper.sv
// Histogram matching mapper: counts two histograms, builds and applies a grey-level map.
// Count and map ops read memory on accept, then write back or give the result in S_EXEC.
// A map result is on rsp_valid in the cycle after the op completes.
// A build makes a cumulative pass over the reference bins; then, per source level, it
// runs S_SRC_RD, S_LHS, S_MUL, a scan of the histogram port and S_MAPWR; then a clear.
// After reset: busy clearing and loading identity; results are never held.
`include "assert_macros.svh"

module histogram_matching_mapper (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  hmm_pkg::op_type           req_op,
   input  logic [hmm_pkg::PIX_W-1:0] req_pixel,
   output logic                      rsp_valid,
   output logic [hmm_pkg::PIX_W-1:0] rsp_mapped_pixel
);
   import hmm_pkg::*;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_CUM_RD = 4'd3;
   localparam logic [3:0] S_CUM_WR = 4'd4;
   localparam logic [3:0] S_SRC_RD = 4'd5;
   localparam logic [3:0] S_LHS    = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_SCAN   = 4'd8;
   localparam logic [3:0] S_MAPWR  = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic               init_ff, init_in;
   logic [HIST_AW-1:0] cnt_ff, cnt_in;
   op_type             op_ff, op_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [CNT_W-1:0]   src_total_ff, src_total_in;
   logic [CNT_W-1:0]   ref_total_ff, ref_total_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]  lhs_ff, lhs_in;
   logic [PROD_W-1:0]  rhs_ff, rhs_in;
   logic [PROD_W-1:0]  best_ff, best_in;
   logic [PIX_W-1:0]   best_j_ff, best_j_in;
   logic [PIX_W:0]     j_iss_ff, j_iss_in;
   logic               s1_v_ff, s1_v_in;
   logic [PIX_W-1:0]   s1_j_ff, s1_j_in;
   logic               s2_v_ff, s2_v_in;
   logic [PIX_W-1:0]   s2_j_ff, s2_j_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pix_ff, rsp_pix_in;

   logic               hist_we;
   logic [HIST_AW-1:0] hist_waddr, hist_raddr;
   logic [CNT_W-1:0]   hist_wdata, hist_rdata;
   logic               map_we;
   logic [PIX_W-1:0]   map_waddr, map_raddr, map_wdata, map_rdata;

   logic               accept;
   logic [PROD_W-1:0]  abs_diff;
   logic               map_exec;
   logic               build_acc;

   hmm_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
      .clock  (clock),
      .wr_en  (hist_we),
      .wr_addr(hist_waddr),
      .wr_data(hist_wdata),
      .rd_addr(hist_raddr),
      .rd_data(hist_rdata)
   );

   hmm_ram #(.WIDTH(PIX_W), .DEPTH(LEVELS)) u_map (
      .clock  (clock),
      .wr_en  (map_we),
      .wr_addr(map_waddr),
      .wr_data(map_wdata),
      .rd_addr(map_raddr),
      .rd_data(map_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign abs_diff  = (lhs_ff >= rhs_ff) ? (lhs_ff - rhs_ff) : (rhs_ff - lhs_ff);
   assign map_exec  = (state_ff == S_EXEC) && (op_ff == OP_MAP);
   assign build_acc = accept && (req_op == OP_BUILD);

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      pix_in       = pix_ff;
      src_total_in = src_total_ff;
      ref_total_in = ref_total_ff;
      acc_in       = acc_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      best_in      = best_ff;
      best_j_in    = best_j_ff;
      j_iss_in     = j_iss_ff;
      s1_v_in      = 1'b0;
      s1_j_in      = j_iss_ff[PIX_W-1:0];
      s2_v_in      = s1_v_ff;
      s2_j_in      = s1_j_ff;
      rsp_valid_in = 1'b0;
      rsp_pix_in   = map_rdata;
      hist_we      = 1'b0;
      hist_waddr   = cnt_ff;
      hist_wdata   = '0;
      hist_raddr   = {req_op[0], req_pixel};
      map_we       = 1'b0;
      map_waddr    = cnt_ff[PIX_W-1:0];
      map_wdata    = cnt_ff[PIX_W-1:0];
      map_raddr    = req_pixel;

      // Second scan stage: keep the lowest j of the smallest distance
      if (s2_v_ff && (s2_j_ff == '0 || abs_diff < best_ff)) begin
         best_in   = abs_diff;
         best_j_in = s2_j_ff;
      end
      if (s1_v_ff) begin
         rhs_in = PROD_W'(hist_rdata) * PROD_W'(src_total_ff);
      end

      case (state_ff)
         S_CLR: begin
            hist_we = 1'b1;
            map_we  = init_ff && !cnt_ff[HIST_AW-1];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               init_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_op;
               pix_in = req_pixel;
               if (req_op == OP_BUILD) begin
                  cnt_in   = '0;
                  acc_in   = '0;
                  state_in = S_CUM_RD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (op_ff)
               OP_COUNT_SRC: begin
                  if (src_total_ff < MAX_PIXELS) begin
                     hist_we      = 1'b1;
                     hist_waddr   = {1'b0, pix_ff};
                     hist_wdata   = hist_rdata + 1'b1;
                     src_total_in = src_total_ff + 1'b1;
                  end
               end
               OP_COUNT_REF: begin
                  if (ref_total_ff < MAX_PIXELS) begin
                     hist_we      = 1'b1;
                     hist_waddr   = {1'b1, pix_ff};
                     hist_wdata   = hist_rdata + 1'b1;
                     ref_total_in = ref_total_ff + 1'b1;
                  end
               end
               OP_MAP: begin
                  rsp_valid_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_CUM_RD: begin
            hist_raddr = {1'b1, cnt_ff[PIX_W-1:0]};
            state_in   = S_CUM_WR;
         end
         S_CUM_WR: begin
            // Replace each reference bin with its running sum
            acc_in     = acc_ff + hist_rdata;
            hist_we    = 1'b1;
            hist_waddr = {1'b1, cnt_ff[PIX_W-1:0]};
            hist_wdata = acc_ff + hist_rdata;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff[PIX_W-1:0] == '1) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = S_SRC_RD;
            end else begin
               state_in = S_CUM_RD;
            end
         end
         S_SRC_RD: begin
            hist_raddr = {1'b0, cnt_ff[PIX_W-1:0]};
            state_in   = S_LHS;
         end
         S_LHS: begin
            acc_in   = acc_ff + hist_rdata;
            state_in = S_MUL;
         end
         S_MUL: begin
            lhs_in   = PROD_W'(acc_ff) * PROD_W'(ref_total_ff);
            j_iss_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            hist_raddr = {1'b1, j_iss_ff[PIX_W-1:0]};
            if (!j_iss_ff[PIX_W]) begin
               s1_v_in  = 1'b1;
               j_iss_in = j_iss_ff + 1'b1;
            end
            if (s2_v_ff && s2_j_ff == '1) begin
               state_in = S_MAPWR;
            end
         end
         S_MAPWR: begin
            map_we    = 1'b1;
            map_waddr = cnt_ff[PIX_W-1:0];
            map_wdata = best_j_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff[PIX_W-1:0] == '1) begin
               // Map done: clear both histograms and totals
               cnt_in       = '0;
               src_total_in = '0;
               ref_total_in = '0;
               state_in     = S_CLR;
            end else begin
               state_in = S_SRC_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         init_ff      <= 1'b1;
         cnt_ff       <= '0;
         src_total_ff <= '0;
         ref_total_ff <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cnt_ff       <= cnt_in;
         src_total_ff <= src_total_in;
         ref_total_ff <= ref_total_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pix_ff     <= pix_in;
      acc_ff     <= acc_in;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      best_ff    <= best_in;
      best_j_ff  <= best_j_in;
      j_iss_ff   <= j_iss_in;
      s1_j_ff    <= s1_j_in;
      s2_j_ff    <= s2_j_in;
      rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = rsp_pix_ff;

   `HMM_ASSERT(a_rsp_after_map, clock, reset, rsp_valid |-> $past(map_exec), "stray result")
   `HMM_ASSERT(a_src_bound, clock, reset, src_total_ff <= MAX_PIXELS, "src total high")
   `HMM_ASSERT(a_ref_bound, clock, reset, ref_total_ff <= MAX_PIXELS, "ref total high")
   `HMM_ASSERT(a_build_starts, clock, reset, build_acc |=> state_ff == S_CUM_RD, "no build")
   `HMM_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy, "idle straight after reset")
endmodule

// File: dv/histogram_matching_mapper_check.sv
// Checker: predicts the grey-level map and compares every mapped pixel result.
`timescale 1ns / 100ps

module histogram_matching_mapper_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  hmm_pkg::op_type           req_op,
   input  logic [hmm_pkg::PIX_W-1:0] req_pixel,
   input  logic                      rsp_valid,
   input  logic [hmm_pkg::PIX_W-1:0] rsp_mapped_pixel,
   output int                        fail_count,
   output int                        pending_count,
   output int                        checked_count
);
   import hmm_pkg::*;

   logic [CNT_W-1:0] src_hist [LEVELS];
   logic [CNT_W-1:0] ref_hist [LEVELS];
   logic [CNT_W-1:0] src_total;
   logic [CNT_W-1:0] ref_total;
   logic [PIX_W-1:0] level_map [LEVELS];
   logic [PIX_W-1:0] mapped_queue [$];

   // Match cumulative counts by exact cross-multiplication; lowest level wins ties.
   task automatic build_level_map();
      logic [63:0] cum_ref [LEVELS];
      logic [63:0] acc;
      logic [63:0] cs;
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic [63:0] diff;
      logic [63:0] best;
      int best_j;
      acc = 0;
      cs = 0;
      for (int j = 0; j < LEVELS; j++) begin
         acc = acc + ref_hist[j];
         cum_ref[j] = acc;
      end
      for (int k = 0; k < LEVELS; k++) begin
         cs = cs + src_hist[k];
         lhs = cs * ref_total;
         best = 0;
         best_j = 0;
         for (int j = 0; j < LEVELS; j++) begin
            rhs = cum_ref[j] * src_total;
            diff = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
            if (j == 0 || diff < best) begin
               best = diff;
               best_j = j;
            end
         end
         level_map[k] = PIX_W'(best_j);
      end
      for (int k = 0; k < LEVELS; k++) begin
         src_hist[k] = '0;
         ref_hist[k] = '0;
      end
      src_total = '0;
      ref_total = '0;
   endtask

   initial begin
      fail_count = 0;
      checked_count = 0;
      src_total = '0;
      ref_total = '0;
      for (int k = 0; k < LEVELS; k++) begin
         src_hist[k] = '0;
         ref_hist[k] = '0;
         level_map[k] = PIX_W'(k);
      end
   end

   assign pending_count = mapped_queue.size();

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (mapped_queue.size() == 0) begin
               $error("unexpected result: mapped_pixel actual %0d", rsp_mapped_pixel);
               fail_count++;
            end else begin
               if (rsp_mapped_pixel !== mapped_queue[0]) begin
                  $error("mismatch mapped_pixel: expected %0d actual %0d",
                         mapped_queue[0], rsp_mapped_pixel);
                  fail_count++;
               end
               void'(mapped_queue.pop_front());
               checked_count++;
            end
         end
         if (start && !busy) begin
            case (req_op)
               OP_COUNT_SRC: begin
                  if (src_total < MAX_PIXELS) begin
                     src_hist[req_pixel]++;
                     src_total++;
                  end
               end
               OP_COUNT_REF: begin
                  if (ref_total < MAX_PIXELS) begin
                     ref_hist[req_pixel]++;
                     ref_total++;
                  end
               end
               OP_BUILD: build_level_map();
               default: mapped_queue.push_back(level_map[req_pixel]);
            endcase
         end
      end
   end
endmodule

// File: dv/histogram_matching_mapper_test.sv
// Testbench top: drives items into the mapper and gives the verdict.
`timescale 1ns / 100ps

module histogram_matching_mapper_test;
   import hmm_pkg::*;

   localparam int WATCHDOG_LIMIT = 250000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   op_type req_op = OP_COUNT_SRC;
   logic [PIX_W-1:0] req_pixel = '0;
   logic busy;
   logic rsp_valid;
   logic [PIX_W-1:0] rsp_mapped_pixel;
   int fail_count;
   int pending_count;
   int checked_count;
   int idle_cycles = 0;
   int item_count = 0;
   int build_count = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   histogram_matching_mapper DUT (.*);

   histogram_matching_mapper_check checker_inst (.*);

   // Count cycles without any accepted item or result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("[histogram_matching_mapper] ERROR");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(op_type op, logic [PIX_W-1:0] pix);
      start <= 1;
      req_op <= op;
      req_pixel <= pix;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      item_count++;
      if (op == OP_BUILD) build_count++;
      @(negedge clock);
   endtask

   task automatic hold_idle(int cycles);
      start <= 0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold off until every expected result has arrived, then let the block settle.
   task automatic drain();
      start <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(int counts, int maps);
      int burst;
      int left;
      left = counts;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_item(OP_MAP, PIX_W'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1) == 0)
               send_item(OP_COUNT_SRC, PIX_W'($urandom_range(0, 255)));
            else
               send_item(OP_COUNT_REF, PIX_W'($urandom_range(0, 255)));
            left--;
         end
         if ($urandom_range(0, 3) != 0) hold_idle($urandom_range(1, 6));
      end
      send_item(OP_BUILD, PIX_W'($urandom_range(0, 255)));
      left = maps;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_item(OP_MAP, PIX_W'($urandom_range(0, 255)));
            left--;
         end
         if ($urandom_range(0, 2) != 0) hold_idle($urandom_range(1, 5));
      end
      drain();
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Identity map after reset, then a build with both histograms empty.
      send_item(OP_MAP, 8'd0);
      send_item(OP_MAP, 8'd255);
      send_item(OP_BUILD, 8'd0);
      send_item(OP_MAP, 8'd0);
      send_item(OP_MAP, 8'd128);
      send_item(OP_MAP, 8'd255);
      drain();
      // Extreme levels in both histograms.
      send_item(OP_COUNT_SRC, 8'd0);
      send_item(OP_COUNT_SRC, 8'd255);
      send_item(OP_COUNT_REF, 8'd0);
      send_item(OP_COUNT_REF, 8'd255);
      send_item(OP_COUNT_REF, 8'd85);
      send_item(OP_COUNT_REF, 8'd170);
      send_item(OP_BUILD, 8'd255);
      send_item(OP_MAP, 8'd0);
      send_item(OP_MAP, 8'd1);
      send_item(OP_MAP, 8'd254);
      send_item(OP_MAP, 8'd255);
      drain();

      // Random phases with bursts and gaps.
      for (int p = 0; p < 3; p++) random_phase(300, 80);

      $display("covered %0d items, %0d map builds, %0d mapped pixels checked",
               item_count, build_count, checked_count);
      $display("including empty-histogram builds and extreme grey levels");
      if (fail_count == 0 && pending_count == 0) begin
         $display("[histogram_matching_mapper] OK");
      end else begin
         $display("failures: %0d, results outstanding: %0d", fail_count, pending_count);
         $display("[histogram_matching_mapper] ERROR");
      end
      $finish;
   end
endmodule
